/* hdl/set_assoc_branch_target_buffer_unit_macros.svh */
`ifndef SET_ASSOC_BRANCH_TARGET_BUFFER_UNIT_MACROS_SVH
`define SET_ASSOC_BRANCH_TARGET_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication: when cond holds, expect holds at that edge.
`define SABTB_ASSERT_NOW(label, clk, rst, cond, expect_now) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
      else $error("sabtb check failed");

// Next-cycle implication: when cond holds, expect holds at the following edge.
`define SABTB_ASSERT_NEXT(label, clk, rst, cond, expect_next) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
      else $error("sabtb check failed");

`endif

/* hdl/sabtb_pkg.sv */
`default_nettype none

package sabtb_pkg;

   localparam int SETS_DEF     = 512;
   localparam int WAYS_DEF     = 4;
   localparam int PC_SHIFT_DEF = 2;

   localparam int PC_W  = 64;
   localparam int TGT_W = 64;
   localparam int OP_W  = 2;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [PC_W-1:0]  pc;
      logic [TGT_W-1:0] new_target;
   } req_payload_type;

   typedef struct packed {
      logic             hit;
      logic [TGT_W-1:0] predicted_target;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic load_rsp;
      logic write_back;
      logic clear_start;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            rsp_busy;
      logic            clear_last;
   } status_type;

endpackage

`default_nettype wire

/* hdl/set_assoc_branch_target_buffer_unit.sv */
`default_nettype none

// Set-associative branch target buffer, SETS sets of WAYS ways, one set row read
// per item from block memory. A lookup or an update is accepted in the idle state,
// which issues the registered read of the set row, then moves to the decide state
// for tag compare, which loads the response register or writes the modified row back.
// A lookup holds in the decide state while an earlier response is still waiting
// to be taken. A clear produces no response: it is accepted, decoded in the decide
// state, then a pass zeroes one row of valid bits per cycle over all SETS rows.
// After reset the same pass runs with req_ready low. Update and clear produce no
// response beat; operation code 3 is accepted and dropped. A miss returns hit low
// and a zero target; when a full set takes a new tag, way 0 is replaced.
module set_assoc_branch_target_buffer_unit #(
   parameter int SETS     = sabtb_pkg::SETS_DEF,
   parameter int WAYS     = sabtb_pkg::WAYS_DEF,
   parameter int PC_SHIFT = sabtb_pkg::PC_SHIFT_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  sabtb_pkg::req_payload_type   req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output sabtb_pkg::rsp_payload_type   rsp_data
);

   sabtb_pkg::cmd_type    cmd;
   sabtb_pkg::status_type status;

   sabtb_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   sabtb_datapath #(
      .SETS     (SETS),
      .WAYS     (WAYS),
      .PC_SHIFT (PC_SHIFT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

/* hdl/sabtb_datapath.sv */
`default_nettype none

module sabtb_datapath #(
   parameter int SETS     = sabtb_pkg::SETS_DEF,
   parameter int WAYS     = sabtb_pkg::WAYS_DEF,
   parameter int PC_SHIFT = sabtb_pkg::PC_SHIFT_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  sabtb_pkg::req_payload_type   req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output sabtb_pkg::rsp_payload_type   rsp_data,
   input  sabtb_pkg::cmd_type           cmd,
   output sabtb_pkg::status_type        status
);

   localparam int TAG_W = sabtb_pkg::PC_W - PC_SHIFT;
   localparam int TGT_W = sabtb_pkg::TGT_W;
   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);
   localparam logic [SET_W-1:0] SET_LAST = SET_W'(SETS - 1);

   logic [WAYS-1:0]                  valid_mem_ff [SETS];
   logic [WAYS-1:0][TAG_W-1:0]       tag_mem_ff   [SETS];
   logic [WAYS-1:0][TGT_W-1:0]       tgt_mem_ff   [SETS];

   sabtb_pkg::req_payload_type       req_ff;
   logic [SET_W-1:0]                 idx_ff;
   logic [SET_W-1:0]                 rd_idx;
   logic [WAYS-1:0]                  rd_valid_ff;
   logic [WAYS-1:0][TAG_W-1:0]       rd_tag_ff;
   logic [WAYS-1:0][TGT_W-1:0]       rd_tgt_ff;

   logic [SET_W-1:0]                 clr_idx_ff, clr_idx_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sabtb_pkg::rsp_payload_type       rsp_data_ff;

   logic [TAG_W-1:0]                 tag;
   logic [WAYS-1:0]                  match;
   logic [WAYS-1:0]                  hit_sel;
   logic [WAYS-1:0]                  free_sel;
   logic [WAYS-1:0]                  victim_sel;
   logic                             hit;
   logic [TGT_W-1:0]                 hit_target;
   logic [WAYS-1:0]                  wr_valid_row;
   logic [WAYS-1:0][TAG_W-1:0]       wr_tag_row;
   logic [WAYS-1:0][TGT_W-1:0]       wr_tgt_row;
   logic                             valid_we;
   logic [SET_W-1:0]                 valid_waddr;
   logic [WAYS-1:0]                  valid_wdata;

   assign rd_idx = req_data.pc[PC_SHIFT +: SET_W] & SET_MASK;
   assign tag    = req_ff.pc[sabtb_pkg::PC_W-1:PC_SHIFT];

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         req_ff      <= req_data;
         idx_ff      <= rd_idx;
         rd_valid_ff <= valid_mem_ff[rd_idx];
         rd_tag_ff   <= tag_mem_ff[rd_idx];
         rd_tgt_ff   <= tgt_mem_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem_ff[valid_waddr] <= valid_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_back) begin
         tag_mem_ff[idx_ff] <= wr_tag_row;
         tgt_mem_ff[idx_ff] <= wr_tgt_row;
      end
   end

   // lowest matching way wins, then lowest free way, else way 0
   always_comb begin
      logic found_hit;
      logic found_free;
      found_hit  = 1'b0;
      found_free = 1'b0;
      hit_sel    = '0;
      free_sel   = '0;
      hit_target = '0;
      for (int w = 0; w < WAYS; w++) begin
         match[w] = rd_valid_ff[w] && (rd_tag_ff[w] == tag);
         if (!found_hit && match[w]) begin
            hit_sel[w] = 1'b1;
            found_hit  = 1'b1;
         end
         if (!found_free && !rd_valid_ff[w]) begin
            free_sel[w] = 1'b1;
            found_free  = 1'b1;
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (hit_sel[w]) begin
            hit_target = rd_tgt_ff[w];
         end
      end
      hit = found_hit;
      if (found_hit) begin
         victim_sel = hit_sel;
      end else if (found_free) begin
         victim_sel = free_sel;
      end else begin
         victim_sel = WAYS'(1);
      end
      for (int w = 0; w < WAYS; w++) begin
         wr_tag_row[w] = victim_sel[w] ? tag : rd_tag_ff[w];
         wr_tgt_row[w] = victim_sel[w] ? req_ff.new_target : rd_tgt_ff[w];
      end
      wr_valid_row = rd_valid_ff | victim_sel;
   end

   always_comb begin
      valid_we    = cmd.write_back || cmd.clear_step;
      valid_waddr = cmd.clear_step ? clr_idx_ff : idx_ff;
      valid_wdata = cmd.clear_step ? '0 : wr_valid_row;
   end

   always_comb begin
      if (cmd.clear_start) begin
         clr_idx_in = '0;
      end else if (cmd.clear_step) begin
         clr_idx_in = clr_idx_ff + SET_W'(1);
      end else begin
         clr_idx_in = clr_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else begin
         clr_idx_ff <= clr_idx_in;
      end
   end

   // response register: hold until the beat is taken
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff.hit              <= hit;
         rsp_data_ff.predicted_target <= hit_target;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.op         = req_ff.operation;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign status.clear_last = (clr_idx_ff == SET_LAST);

endmodule

`default_nettype wire

/* hdl/sabtb_controller.sv */
`default_nettype none

module sabtb_controller (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   output sabtb_pkg::cmd_type      cmd,
   input  sabtb_pkg::status_type   status
);

   sabtb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sabtb_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sabtb_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = sabtb_pkg::ST_IDLE;
            end
         end
         sabtb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sabtb_pkg::ST_DECIDE;
            end
         end
         sabtb_pkg::ST_DECIDE: begin
            case (status.op)
               sabtb_pkg::OP_LOOKUP: begin
                  if (!status.rsp_busy) begin
                     state_in = sabtb_pkg::ST_IDLE;
                  end
               end
               sabtb_pkg::OP_CLEAR: state_in = sabtb_pkg::ST_CLEAR;
               default:             state_in = sabtb_pkg::ST_IDLE;
            endcase
         end
         default: state_in = sabtb_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      cmd             = '0;
      case (state_ff)
         sabtb_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         sabtb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.rd_en = req_valid;
         end
         sabtb_pkg::ST_DECIDE: begin
            case (status.op)
               sabtb_pkg::OP_LOOKUP: cmd.load_rsp    = !status.rsp_busy;
               sabtb_pkg::OP_UPDATE: cmd.write_back  = 1'b1;
               sabtb_pkg::OP_CLEAR:  cmd.clear_start = 1'b1;
               default:              cmd           = '0;
            endcase
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/sabtb_checker.sv */
`default_nettype none
`include "set_assoc_branch_target_buffer_unit_macros.svh"

module sabtb_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input sabtb_pkg::rsp_payload_type   rsp_data
);

   // a stalled response beat holds its payload
   `SABTB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // the clearing pass keeps the request side closed right after reset
   `SABTB_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_ready)

   // every accepted beat occupies the block for at least the compare cycle
   `SABTB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a new response appears only out of a compare cycle
   `SABTB_ASSERT_NOW(a_rsp_from_compare, clock, reset, $rose(rsp_valid), !$past(req_ready))

endmodule

bind set_assoc_branch_target_buffer_unit sabtb_checker u_sabtb_checker (.*);

`default_nettype wire

/* test/set_assoc_branch_target_buffer_unit_tb.sv */
`timescale 1ns / 100ps

module set_assoc_branch_target_buffer_unit_tb;
   import sabtb_pkg::*;

   localparam int ENTRIES      = SETS_DEF * WAYS_DEF;
   localparam int TAG_W        = PC_W - PC_SHIFT_DEF;
   localparam int SET_BITS     = $clog2(SETS_DEF);
   localparam int UPPER_W      = PC_W - SET_BITS - PC_SHIFT_DEF;
   localparam int RANDOM_ITEMS = 1700;
   localparam int CYCLE_LIMIT  = 300000;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;
   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [PC_W-1:0]  pc;
      logic [TGT_W-1:0] tgt;
      logic             pinned;
      logic             hit;
      logic [TGT_W-1:0] exp_tgt;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   // Typed-in expectation travels with the beat it belongs to.
   logic pinned_use = 1'b0;
   rsp_payload_type pinned_rsp = '0;

   logic                 way_valid [ENTRIES];
   logic [TAG_W-1:0]     way_tag [ENTRIES];
   logic [TGT_W-1:0]     way_target [ENTRIES];
   rsp_payload_type      pending_lookups [$];
   logic                 model_has_rsp;
   rsp_payload_type      model_rsp;
   rsp_payload_type      oldest;
   int                   fail_count = 0;
   int                   cycle_count = 0;
   logic                 sender_quiet = 1'b0;
   logic                 receiver_quiet = 1'b0;
   logic [UPPER_W-1:0]   hot_upper [6];
   logic [SET_BITS-1:0]  hot_set [8];

   always #5 clock = ~clock;

   set_assoc_branch_target_buffer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function automatic void btb_predict(input req_payload_type item, output logic produces,
                                       output rsp_payload_type result);
      logic [TAG_W-1:0] tag;
      int base;
      int match_way;
      int fill_way;
      tag = TAG_W'(item.pc >> PC_SHIFT_DEF);
      base = int'(tag & TAG_W'(SETS_DEF - 1)) * WAYS_DEF;
      match_way = WAYS_DEF;
      for (int w = WAYS_DEF - 1; w >= 0; w--)
         if (way_valid[base + w] && way_tag[base + w] == tag) match_way = w;
      produces = 1'b0;
      result = '0;
      case (item.operation)
         OP_LOOKUP: begin
            produces = 1'b1;
            if (match_way < WAYS_DEF) begin
               result.hit = 1'b1;
               result.predicted_target = way_target[base + match_way];
            end
         end
         OP_UPDATE: begin
            if (match_way < WAYS_DEF) begin
               way_target[base + match_way] = item.new_target;
            end else begin
               // lowest invalid way, or way 0 when the set is full
               fill_way = 0;
               for (int w = WAYS_DEF - 1; w >= 0; w--)
                  if (!way_valid[base + w]) fill_way = w;
               way_valid[base + fill_way] = 1'b1;
               way_tag[base + fill_way] = tag;
               way_target[base + fill_way] = item.new_target;
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) way_valid[i] = 1'b0;
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input req_payload_type item, input logic use_pin,
                            input rsp_payload_type pin);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      pinned_use <= use_pin;
      pinned_rsp <= pin;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold off the sender until every lookup beat has come back.
   task automatic drain_lookups();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_lookups.size() != 0);
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            btb_predict(req_data, model_has_rsp, model_rsp);
            if (model_has_rsp)
               pending_lookups.push_back(pinned_use ? pinned_rsp : model_rsp);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_lookups.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response beat, actual hit %0b target %h",
                        $time, rsp_data.hit, rsp_data.predicted_target);
            end else begin
               oldest = pending_lookups.pop_front();
               if (rsp_data.hit !== oldest.hit) begin
                  fail_count++;
                  $display("%0t: hit mismatch, expected %0b actual %0b",
                           $time, oldest.hit, rsp_data.hit);
               end
               if (rsp_data.predicted_target !== oldest.predicted_target) begin
                  fail_count++;
                  $display("%0t: predicted_target mismatch, expected %h actual %h",
                           $time, oldest.predicted_target, rsp_data.predicted_target);
               end
            end
         end
      end
   end

   initial begin
      int stall;
      int beats;
      beats = 0;
      while (reset) @(posedge clock);
      forever begin
         if (beats % 32 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
         stall = receiver_quiet ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beats++;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      stim_row_type stim_rows [$];
      req_payload_type item;
      rsp_payload_type pin;
      int r;
      int pick;

      for (int i = 0; i < ENTRIES; i++) way_valid[i] = 1'b0;
      for (int i = 0; i < 6; i++) hot_upper[i] = UPPER_W'({$urandom, $urandom});
      for (int i = 0; i < 8; i++) hot_set[i] = SET_BITS'($urandom);

      // empty after reset, both pc extremes
      stim_rows.push_back('{OP_LOOKUP, 64'h0, 64'h0, 1'b1, 1'b0, 64'h0});
      stim_rows.push_back('{OP_LOOKUP, ONES, 64'h0, 1'b1, 1'b0, 64'h0});
      stim_rows.push_back('{OP_UPDATE, 64'h0, ONES, 1'b0, 1'b0, 64'h0});
      stim_rows.push_back('{OP_LOOKUP, 64'h0, 64'h0, 1'b1, 1'b1, ONES});
      // low pc bits are below the tag
      stim_rows.push_back('{OP_LOOKUP, 64'h3, 64'h0, 1'b0, 1'b0, 64'h0});
      stim_rows.push_back('{OP_UPDATE, ONES, 64'h0, 1'b0, 1'b0, 64'h0});
      stim_rows.push_back('{OP_LOOKUP, ONES, 64'h0, 1'b1, 1'b1, 64'h0});
      // same set, tag differs only in the top bit
      stim_rows.push_back('{OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 1'b0, 64'h0});
      // overfill one set: the fifth tag evicts way 0
      for (int k = 0; k < 5; k++)
         stim_rows.push_back('{OP_UPDATE, {UPPER_W'(k * 7 + 1), SET_BITS'(5), 2'd0},
                               {32'hA5A5_0000, 32'(k)}, 1'b0, 1'b0, 64'h0});
      for (int k = 0; k < 5; k++)
         stim_rows.push_back('{OP_LOOKUP, {UPPER_W'(k * 7 + 1), SET_BITS'(5), 2'd0},
                               64'h0, 1'b0, 1'b0, 64'h0});
      // rewrite on hit
      stim_rows.push_back('{OP_UPDATE, {UPPER_W'(8), SET_BITS'(5), 2'd2}, 64'h1234_5678_9ABC_DEF0,
                            1'b0, 1'b0, 64'h0});
      stim_rows.push_back('{OP_LOOKUP, {UPPER_W'(8), SET_BITS'(5), 2'd0}, 64'h0,
                            1'b0, 1'b0, 64'h0});
      // unused code does nothing
      stim_rows.push_back('{OP_NONE, ONES, ONES, 1'b0, 1'b0, 64'h0});
      stim_rows.push_back('{OP_LOOKUP, ONES, 64'h0, 1'b0, 1'b0, 64'h0});
      stim_rows.push_back('{OP_CLEAR, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0});
      stim_rows.push_back('{OP_LOOKUP, 64'h0, 64'h0, 1'b1, 1'b0, 64'h0});
      stim_rows.push_back('{OP_LOOKUP, ONES, 64'h0, 1'b1, 1'b0, 64'h0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         item.operation = stim_rows[i].op;
         item.pc = stim_rows[i].pc;
         item.new_target = stim_rows[i].tgt;
         pin.hit = stim_rows[i].hit;
         pin.predicted_target = stim_rows[i].exp_tgt;
         send_item(item, stim_rows[i].pinned, pin);
      end
      drain_lookups();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
         if (n % 400 == 399) drain_lookups();
         r = $urandom_range(0, 99);
         if (r < 50)      item.operation = OP_LOOKUP;
         else if (r < 95) item.operation = OP_UPDATE;
         else if (r < 96) item.operation = OP_CLEAR;
         else             item.operation = OP_NONE;
         // mostly a few crowded sets so hits and evictions stay frequent
         pick = $urandom_range(0, 9);
         if (pick < 8)
            item.pc = {hot_upper[$urandom_range(0, 5)], hot_set[$urandom_range(0, 7)],
                       2'($urandom_range(0, 3))};
         else
            item.pc = {$urandom, $urandom};
         item.new_target = {$urandom, $urandom};
         send_item(item, 1'b0, '0);
      end
      drain_lookups();
      // let a trailing clear pass finish
      repeat (SETS_DEF + 16) @(posedge clock);

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
